// ===== src/ipfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ipfd_pkg
// widths, codes, item types and the route selection helper shared by the
// forwarding decision pipeline
// ----------------------------------------------------------------------------
package ipfd_pkg;

  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 4;
  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 2;
  localparam int ETYPE_W    = 16;
  localparam int BYTE_W     = 8;
  localparam int OP_W       = 16;
  localparam int ACT_W      = 3;
  localparam int CODE_W     = 4;
  localparam int RCNT_W     = 5;
  localparam int ICNT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int SLOT_SPAN = 1 << SLOT_W;
  localparam int PORT_SPAN = 1 << PORT_W;

  localparam int ROUTE_ENTRIES_DEF = 16;
  localparam int IFACE_ENTRIES_DEF = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ROUTE    = 2'd0,
    CMD_IFACE    = 2'd1,
    CMD_CLASSIFY = 2'd2
  } cmd_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_DROP   = 3'd0,
    ACT_ICMP   = 3'd1,
    ACT_FWD    = 3'd2,
    ACT_LEARN  = 3'd3,
    ACT_ANSWER = 3'd4,
    ACT_WDONE  = 3'd5
  } action_e;

  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_COUNT = 2'd1;

  localparam logic [ETYPE_W-1:0] ET_IPV4 = 16'h0800;
  localparam logic [ETYPE_W-1:0] ET_IPV6 = 16'h86DD;
  localparam logic [ETYPE_W-1:0] ET_ARP  = 16'h0806;

  localparam logic [BYTE_W-1:0] PR_ICMP = 8'd1;
  localparam logic [BYTE_W-1:0] PR_TCP  = 8'd6;
  localparam logic [BYTE_W-1:0] PR_UDP  = 8'd17;

  localparam logic [BYTE_W-1:0] IC_ECHO_REQ   = 8'd8;
  localparam logic [BYTE_W-1:0] IC_ECHO_REPLY = 8'd0;
  localparam logic [BYTE_W-1:0] IC_UNREACH    = 8'd3;
  localparam logic [BYTE_W-1:0] IC_TIME_EXC   = 8'd11;

  localparam logic [CODE_W-1:0] UC_NET   = 4'd0;
  localparam logic [CODE_W-1:0] UC_HOST  = 4'd1;
  localparam logic [CODE_W-1:0] UC_PROTO = 4'd2;
  localparam logic [CODE_W-1:0] UC_PORT  = 4'd3;

  localparam logic [BYTE_W-1:0] TTL_ONE = 8'd1;
  localparam logic [OP_W-1:0]   ARP_REQ_CODE   = 16'd1;
  localparam logic [OP_W-1:0]   ARP_REPLY_CODE = 16'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  gateway;
    logic [PORT_W-1:0]  port;
    logic [ETYPE_W-1:0] ethertype;
    logic [BYTE_W-1:0]  proto;
    logic [BYTE_W-1:0]  ttl;
    logic [BYTE_W-1:0]  icmp_kind;
    logic [OP_W-1:0]    arp_op;
  } item_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              is_ip;
    logic              is_arp;
    logic              ingress;
    logic              router_if;
    logic              l4_port;
    logic              ttl_one;
    logic              is_icmp;
    logic              echo_req;
    logic              arp_reply;
    logic              arp_request;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
  } hdr_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] egress;
  } cand_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] icmp_out_type;
    logic [CODE_W-1:0] icmp_out_code;
    logic [PORT_W-1:0] out_port;
    logic [ADDR_W-1:0] next_hop;
    logic              ttl_expired;
  } res_t;

  // longer mask wins, lower entry keeps a tie
  function automatic cand_t cand_pick(cand_t lo, cand_t hi);
    if (hi.hit && (!lo.hit || (lo.mask < hi.mask))) begin
      return hi;
    end
    return lo;
  endfunction

endpackage

// ===== src/ipfd_ifs.sv =====
// ----------------------------------------------------------------------------
// ipfd channel interfaces
// input item, result item and configuration write channels
// ----------------------------------------------------------------------------
interface ipfd_in_if import ipfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [SLOT_W-1:0]  slot;
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  mask;
  logic [ADDR_W-1:0]  gateway;
  logic [PORT_W-1:0]  port;
  logic [ETYPE_W-1:0] ethertype;
  logic [BYTE_W-1:0]  proto;
  logic [BYTE_W-1:0]  ttl;
  logic [BYTE_W-1:0]  icmp_kind;
  logic [OP_W-1:0]    arp_op;

  modport source (
    output valid, cmd, slot, addr, mask, gateway, port, ethertype, proto, ttl,
           icmp_kind, arp_op,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot, addr, mask, gateway, port, ethertype, proto, ttl,
           icmp_kind, arp_op,
    output ready
  );
endinterface

interface ipfd_out_if import ipfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] icmp_out_type;
  logic [CODE_W-1:0] icmp_out_code;
  logic [PORT_W-1:0] out_port;
  logic [ADDR_W-1:0] next_hop;
  logic              ttl_expired;

  modport source (
    output valid, action, icmp_out_type, icmp_out_code, out_port, next_hop,
           ttl_expired,
    input  ready
  );
  modport sink (
    input  valid, action, icmp_out_type, icmp_out_code, out_port, next_hop,
           ttl_expired,
    output ready
  );
endinterface

interface ipfd_cfg_if import ipfd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ipfd_tables.sv =====
// ----------------------------------------------------------------------------
// ipfd_tables
// route and interface tables, per-entry match lanes and header predicates,
// registered into the candidate stage
// ----------------------------------------------------------------------------
module ipfd_tables import ipfd_pkg::*; #(
  parameter int ROUTE_DEPTH = ROUTE_ENTRIES_DEF,
  parameter int IFACE_DEPTH = IFACE_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  item_t             item_i,
  input  logic [RCNT_W-1:0] route_count_i,
  input  logic [ICNT_W-1:0] iface_count_i,
  output logic              valid_o,
  output hdr_t              hdr_o,
  output cand_t             cand_o [ROUTE_DEPTH]
);

  logic [ADDR_W-1:0] prefix_q  [ROUTE_DEPTH];
  logic [ADDR_W-1:0] netmask_q [ROUTE_DEPTH];
  logic [ADDR_W-1:0] gateway_q [ROUTE_DEPTH];
  logic [PORT_W-1:0] egress_q  [ROUTE_DEPTH];
  logic [ADDR_W-1:0] iface_q   [IFACE_DEPTH];

  logic  valid_q;
  hdr_t  hdr_q, hdr_d;
  cand_t cand_q [ROUTE_DEPTH];
  cand_t cand_d [ROUTE_DEPTH];
  logic  wr_route, wr_iface;

  assign wr_route = en_i && valid_i && (item_i.cmd == CMD_ROUTE);
  assign wr_iface = en_i && valid_i && (item_i.cmd == CMD_IFACE);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ROUTE_DEPTH; i++) begin
      if (wr_route && (item_i.slot == SLOT_W'(i))) begin
        prefix_q[i]  <= item_i.addr;
        netmask_q[i] <= item_i.mask;
        gateway_q[i] <= item_i.gateway;
        egress_q[i]  <= item_i.port;
      end
    end
    for (int i = 0; i < IFACE_DEPTH; i++) begin
      if (wr_iface && (item_i.slot == SLOT_W'(i))) begin
        iface_q[i] <= item_i.addr;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ROUTE_DEPTH; i++) begin
      cand_d[i].hit     = ((item_i.addr & netmask_q[i]) == prefix_q[i]) &&
                          (RCNT_W'(i) < route_count_i);
      cand_d[i].mask    = netmask_q[i];
      cand_d[i].gateway = gateway_q[i];
      cand_d[i].egress  = egress_q[i];
    end
  end

  always_comb begin
    hdr_d             = '0;
    hdr_d.cmd         = item_i.cmd;
    hdr_d.is_ip       = (item_i.ethertype == ET_IPV4) || (item_i.ethertype == ET_IPV6);
    hdr_d.is_arp      = (item_i.ethertype == ET_ARP);
    hdr_d.l4_port     = (item_i.proto == PR_TCP) || (item_i.proto == PR_UDP);
    hdr_d.ttl_one     = (item_i.ttl == TTL_ONE);
    hdr_d.is_icmp     = (item_i.proto == PR_ICMP);
    hdr_d.echo_req    = (item_i.icmp_kind == IC_ECHO_REQ);
    hdr_d.arp_reply   = (item_i.arp_op == ARP_REPLY_CODE);
    hdr_d.arp_request = (item_i.arp_op == ARP_REQ_CODE);
    hdr_d.port        = item_i.port;
    hdr_d.addr        = item_i.addr;
    for (int i = 0; i < IFACE_DEPTH; i++) begin
      if (iface_q[i] == item_i.addr) begin
        if ((RCNT_W'(i) < {{(RCNT_W-ICNT_W){1'b0}}, iface_count_i})) begin
          hdr_d.router_if = 1'b1;
        end
        if ((i < PORT_SPAN) && (item_i.port == PORT_W'(i))) begin
          hdr_d.ingress = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hdr_q  <= hdr_d;
      cand_q <= cand_d;
    end
  end

  assign valid_o = valid_q;
  assign hdr_o   = hdr_q;
  assign cand_o  = cand_q;

endmodule

// ===== src/ipfd_lpm_tree.sv =====
// ----------------------------------------------------------------------------
// ipfd_lpm_tree
// registered pairwise selection tree picking the longest matching route,
// one tree level per stage, header carried alongside
// ----------------------------------------------------------------------------
module ipfd_lpm_tree import ipfd_pkg::*; #(
  parameter int ROUTE_DEPTH = ROUTE_ENTRIES_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  hdr_t  hdr_i,
  input  cand_t leaf_i [ROUTE_DEPTH],
  output logic  valid_o,
  output hdr_t  hdr_o,
  output cand_t best_o
);

  localparam int Levels = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int Pow    = 1 << Levels;
  localparam int Nodes  = 2 * Pow - 1;

  cand_t node_q [Pow-1];
  cand_t node_d [Pow-1];
  cand_t tree   [Nodes];
  logic  valid_q [Levels];
  hdr_t  hdr_q   [Levels];

  always_comb begin
    for (int k = 0; k < Pow - 1; k++) begin
      tree[k] = node_q[k];
    end
    for (int j = 0; j < Pow; j++) begin
      if (j < ROUTE_DEPTH) begin
        tree[Pow-1+j] = leaf_i[j];
      end else begin
        tree[Pow-1+j] = '0;
      end
    end
    for (int k = 0; k < Pow - 1; k++) begin
      node_d[k] = cand_pick(tree[2*k+1], tree[2*k+2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < Levels; l++) begin
        valid_q[l] <= 1'b0;
      end
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int l = 1; l < Levels; l++) begin
        valid_q[l] <= valid_q[l-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      node_q   <= node_d;
      hdr_q[0] <= hdr_i;
      for (int l = 1; l < Levels; l++) begin
        hdr_q[l] <= hdr_q[l-1];
      end
    end
  end

  assign valid_o = valid_q[Levels-1];
  assign hdr_o   = hdr_q[Levels-1];
  assign best_o  = node_q[0];

endmodule

// ===== src/ipfd_decide.sv =====
// ----------------------------------------------------------------------------
// ipfd_decide
// final action decision and result register
// ----------------------------------------------------------------------------
module ipfd_decide import ipfd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  hdr_t  hdr_i,
  input  cand_t best_i,
  output logic  valid_o,
  output res_t  res_o
);

  logic valid_q;
  res_t res_q, res_d;

  always_comb begin
    res_d = '0;
    res_d.action = ACT_DROP;
    case (hdr_i.cmd)
      CMD_ROUTE, CMD_IFACE: begin
        res_d.action = ACT_WDONE;
      end
      CMD_CLASSIFY: begin
        if (hdr_i.is_ip) begin
          if (hdr_i.ingress) begin
            if (hdr_i.l4_port) begin
              res_d.action        = ACT_ICMP;
              res_d.icmp_out_type = IC_UNREACH;
              res_d.icmp_out_code = UC_PORT;
              res_d.out_port      = hdr_i.port;
            end else if (hdr_i.ttl_one) begin
              res_d.action        = ACT_ICMP;
              res_d.icmp_out_type = IC_TIME_EXC;
              res_d.out_port      = hdr_i.port;
            end else if (hdr_i.is_icmp) begin
              if (hdr_i.echo_req) begin
                res_d.action        = ACT_ICMP;
                res_d.icmp_out_type = IC_ECHO_REPLY;
                res_d.out_port      = hdr_i.port;
              end
            end else begin
              res_d.action        = ACT_ICMP;
              res_d.icmp_out_type = IC_UNREACH;
              res_d.icmp_out_code = UC_PROTO;
              res_d.out_port      = hdr_i.port;
            end
          end else if (hdr_i.router_if) begin
            res_d.action        = ACT_ICMP;
            res_d.icmp_out_type = IC_UNREACH;
            res_d.icmp_out_code = UC_HOST;
            res_d.out_port      = hdr_i.port;
          end else if (!best_i.hit) begin
            res_d.action        = ACT_ICMP;
            res_d.icmp_out_type = IC_UNREACH;
            res_d.icmp_out_code = UC_NET;
            res_d.out_port      = hdr_i.port;
          end else begin
            res_d.action      = ACT_FWD;
            res_d.out_port    = best_i.egress;
            res_d.next_hop    = (best_i.gateway != '0) ? best_i.gateway : hdr_i.addr;
            res_d.ttl_expired = hdr_i.ttl_one;
          end
        end else if (hdr_i.is_arp && hdr_i.ingress) begin
          if (hdr_i.arp_reply) begin
            res_d.action   = ACT_LEARN;
            res_d.out_port = hdr_i.port;
          end else if (hdr_i.arp_request) begin
            res_d.action   = ACT_ANSWER;
            res_d.out_port = hdr_i.port;
          end
        end
      end
      default: begin
        res_d.action = ACT_DROP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== src/ip_router_forwarding_decision.sv =====
// ----------------------------------------------------------------------------
// ip_router_forwarding_decision
// ipv4 and ipv6 forwarding decision with longest-prefix route match
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled: route writes,
// interface writes and packet headers each give one result, in order. The
// pipeline is an input register, a match stage that reads every route and
// interface entry in parallel, one register stage per level of the route
// selection tree (log2 of the route table depth, at least one), and the
// result register. The whole pipeline holds while a result waits on the
// output. A table write takes effect for every item accepted after it.
// Only slots 0 to 15 are addressable, so the stored tables hold at most 16
// entries whatever the entry parameters are. Configuration writes are always
// taken.
module ip_router_forwarding_decision import ipfd_pkg::*; #(
  parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
  parameter int IFACE_ENTRIES = IFACE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ipfd_in_if.sink     in_i,
  ipfd_out_if.source  out_o,
  ipfd_cfg_if.sink    cfg_i
);

  localparam int RouteDepth = (ROUTE_ENTRIES < SLOT_SPAN) ? ROUTE_ENTRIES : SLOT_SPAN;
  localparam int IfaceDepth = (IFACE_ENTRIES < SLOT_SPAN) ? IFACE_ENTRIES : SLOT_SPAN;

  logic              en;
  logic              s1_valid_q;
  item_t             s1_item_q;
  logic [RCNT_W-1:0] route_count_q;
  logic [ICNT_W-1:0] iface_count_q;

  logic  s2_valid;
  hdr_t  s2_hdr;
  cand_t s2_cand [RouteDepth];
  logic  tr_valid;
  hdr_t  tr_hdr;
  cand_t tr_best;
  logic  res_valid;
  res_t  res;

  assign en         = !res_valid || out_o.ready;
  assign in_i.ready = en;
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_count_q <= '0;
      iface_count_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ROUTE_COUNT: route_count_q <= cfg_i.data[RCNT_W-1:0];
        CFG_IFACE_COUNT: iface_count_q <= cfg_i.data[ICNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_item_q.cmd       <= in_i.cmd;
      s1_item_q.slot      <= in_i.slot;
      s1_item_q.addr      <= in_i.addr;
      s1_item_q.mask      <= in_i.mask;
      s1_item_q.gateway   <= in_i.gateway;
      s1_item_q.port      <= in_i.port;
      s1_item_q.ethertype <= in_i.ethertype;
      s1_item_q.proto     <= in_i.proto;
      s1_item_q.ttl       <= in_i.ttl;
      s1_item_q.icmp_kind <= in_i.icmp_kind;
      s1_item_q.arp_op    <= in_i.arp_op;
    end
  end

  ipfd_tables #(
    .ROUTE_DEPTH (RouteDepth),
    .IFACE_DEPTH (IfaceDepth)
  ) u_tables (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (s1_valid_q),
    .item_i        (s1_item_q),
    .route_count_i (route_count_q),
    .iface_count_i (iface_count_q),
    .valid_o       (s2_valid),
    .hdr_o         (s2_hdr),
    .cand_o        (s2_cand)
  );

  ipfd_lpm_tree #(
    .ROUTE_DEPTH (RouteDepth)
  ) u_lpm_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_valid),
    .hdr_i   (s2_hdr),
    .leaf_i  (s2_cand),
    .valid_o (tr_valid),
    .hdr_o   (tr_hdr),
    .best_o  (tr_best)
  );

  ipfd_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tr_valid),
    .hdr_i   (tr_hdr),
    .best_i  (tr_best),
    .valid_o (res_valid),
    .res_o   (res)
  );

  assign out_o.valid         = res_valid;
  assign out_o.action        = res.action;
  assign out_o.icmp_out_type = res.icmp_out_type;
  assign out_o.icmp_out_code = res.icmp_out_code;
  assign out_o.out_port      = res.out_port;
  assign out_o.next_hop      = res.next_hop;
  assign out_o.ttl_expired   = res.ttl_expired;

endmodule

// ===== tb/sv/tb_ip_router_forwarding_decision.sv =====
// ----------------------------------------------------------------------------
// tb_ip_router_forwarding_decision
// self-checking bench for the forwarding decision pipeline: table writes and
// packet headers go in through bursty transfers, each decision coming out is
// compared with a software copy of the route and interface tables, while the
// result side stalls on changing patterns and both count registers are swept
// ----------------------------------------------------------------------------
module tb_ip_router_forwarding_decision;
  timeunit 1ns;
  timeprecision 1ps;
  import ipfd_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int PHASES           = 10;
  localparam int RANDOM_PER_PHASE = 121;

  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [CODE_W-1:0] CODE_NONE  = 4'd0;

  localparam logic [CFG_DATA_W-1:0] ROUTE_CFG [PHASES] =
    '{8'd16, 8'd0, 8'd31, 8'd1, 8'd8, 8'hFF, 8'd16, 8'd5, 8'd12, 8'd17};
  localparam logic [CFG_DATA_W-1:0] IFACE_CFG [PHASES] =
    '{8'd4, 8'd0, 8'd7, 8'd1, 8'd2, 8'hFF, 8'd0, 8'd3, 8'd4, 8'd4};

  localparam logic [ADDR_W-1:0] IF0 = 32'h0A000001;
  localparam logic [ADDR_W-1:0] IF1 = 32'h0A010001;
  localparam logic [ADDR_W-1:0] IF2 = 32'hC0A80001;
  localparam logic [ADDR_W-1:0] IF3 = 32'hFFFFFFFF;

  class fwd_decision_board;
    logic [ADDR_W-1:0] rt_prefix [ROUTE_ENTRIES_DEF];
    logic [ADDR_W-1:0] rt_mask   [ROUTE_ENTRIES_DEF];
    logic [ADDR_W-1:0] rt_gw     [ROUTE_ENTRIES_DEF];
    logic [PORT_W-1:0] rt_port   [ROUTE_ENTRIES_DEF];
    logic [ADDR_W-1:0] ifc_addr  [IFACE_ENTRIES_DEF];
    logic [RCNT_W-1:0] route_count;
    logic [ICNT_W-1:0] iface_count;
    res_t pending_decisions [$];
    int mismatches;
    int noted;
    int checked;
    int per_action [8];

    function new();
      foreach (rt_prefix[i]) begin
        rt_prefix[i] = '0;
        rt_mask[i]   = '0;
        rt_gw[i]     = '0;
        rt_port[i]   = '0;
      end
      foreach (ifc_addr[i]) ifc_addr[i] = '0;
      foreach (per_action[i]) per_action[i] = 0;
      route_count = '0;
      iface_count = '0;
      mismatches  = 0;
      noted       = 0;
      checked     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ROUTE_COUNT) begin
        route_count = data[RCNT_W-1:0];
      end else if (idx == CFG_IFACE_COUNT) begin
        iface_count = data[ICNT_W-1:0];
      end
    endfunction

    function res_t icmp_msg(logic [BYTE_W-1:0] ty, logic [CODE_W-1:0] code,
                            logic [PORT_W-1:0] prt);
      res_t r;
      r = '0;
      r.action        = ACT_ICMP;
      r.icmp_out_type = ty;
      r.icmp_out_code = code;
      r.out_port      = prt;
      return r;
    endfunction

    function res_t decide(item_t it);
      res_t r;
      int   best;
      int   n;
      bit   known_if;
      r = '0;
      case (it.cmd)
        CMD_ROUTE: begin
          if (it.slot < ROUTE_ENTRIES_DEF) begin
            rt_prefix[it.slot] = it.addr;
            rt_mask[it.slot]   = it.mask;
            rt_gw[it.slot]     = it.gateway;
            rt_port[it.slot]   = it.port;
          end
          r.action = ACT_WDONE;
        end
        CMD_IFACE: begin
          if (it.slot < IFACE_ENTRIES_DEF) ifc_addr[it.slot] = it.addr;
          r.action = ACT_WDONE;
        end
        CMD_CLASSIFY: begin
          if (it.ethertype == ET_IPV4 || it.ethertype == ET_IPV6) begin
            if (ifc_addr[it.port] == it.addr) begin
              if (it.proto == PR_TCP || it.proto == PR_UDP) begin
                r = icmp_msg(IC_UNREACH, UC_PORT, it.port);
              end else if (it.ttl == TTL_ONE) begin
                r = icmp_msg(IC_TIME_EXC, CODE_NONE, it.port);
              end else if (it.proto == PR_ICMP) begin
                if (it.icmp_kind == IC_ECHO_REQ) r = icmp_msg(IC_ECHO_REPLY, CODE_NONE, it.port);
              end else begin
                r = icmp_msg(IC_UNREACH, UC_PROTO, it.port);
              end
            end else begin
              known_if = 1'b0;
              n = (iface_count > IFACE_ENTRIES_DEF) ? IFACE_ENTRIES_DEF : iface_count;
              for (int i = 0; i < n; i++) begin
                if (ifc_addr[i] == it.addr) known_if = 1'b1;
              end
              if (known_if) begin
                r = icmp_msg(IC_UNREACH, UC_HOST, it.port);
              end else begin
                // longest mask wins, lower entry keeps a tie
                best = -1;
                n = (route_count > ROUTE_ENTRIES_DEF) ? ROUTE_ENTRIES_DEF : route_count;
                for (int i = 0; i < n; i++) begin
                  if ((it.addr & rt_mask[i]) == rt_prefix[i] &&
                      (best < 0 || rt_mask[best] < rt_mask[i])) best = i;
                end
                if (best < 0) begin
                  r = icmp_msg(IC_UNREACH, UC_NET, it.port);
                end else begin
                  r.action      = ACT_FWD;
                  r.out_port    = rt_port[best];
                  r.next_hop    = (rt_gw[best] != '0) ? rt_gw[best] : it.addr;
                  r.ttl_expired = (it.ttl == TTL_ONE);
                end
              end
            end
          end else if (it.ethertype == ET_ARP && ifc_addr[it.port] == it.addr) begin
            if (it.arp_op == ARP_REPLY_CODE) begin
              r.action   = ACT_LEARN;
              r.out_port = it.port;
            end else if (it.arp_op == ARP_REQ_CODE) begin
              r.action   = ACT_ANSWER;
              r.out_port = it.port;
            end
          end
        end
        default: r.action = ACT_DROP;
      endcase
      return r;
    endfunction

    function void note_item(item_t it);
      pending_decisions.push_back(decide(it));
      noted++;
    endfunction

    function void cmp_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] seen);
      if (seen !== want) begin
        $error("%s expected %0h got %0h", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_decision(res_t got);
      res_t want;
      if (pending_decisions.size() == 0) begin
        $error("result with no decision pending, action %0d", got.action);
        mismatches++;
        return;
      end
      want = pending_decisions.pop_front();
      checked++;
      per_action[got.action]++;
      cmp_field("action", ADDR_W'(want.action), ADDR_W'(got.action));
      cmp_field("icmp_out_type", ADDR_W'(want.icmp_out_type), ADDR_W'(got.icmp_out_type));
      cmp_field("icmp_out_code", ADDR_W'(want.icmp_out_code), ADDR_W'(got.icmp_out_code));
      cmp_field("out_port", ADDR_W'(want.out_port), ADDR_W'(got.out_port));
      cmp_field("next_hop", want.next_hop, got.next_hop);
      cmp_field("ttl_expired", ADDR_W'(want.ttl_expired), ADDR_W'(got.ttl_expired));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ipfd_in_if  in_if ();
  ipfd_out_if out_if ();
  ipfd_cfg_if cfg_if ();

  ip_router_forwarding_decision dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  fwd_decision_board board;
  int idle_cycles = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;
  int stall_tick  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transfer monitor, all sampling on the rising edge
  always @(posedge clk_i) begin
    item_t seen;
    res_t  got;
    bit    moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
        board.set_reg(cfg_if.index, cfg_if.data);
        moved = 1'b1;
      end
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        seen.cmd       = in_if.cmd;
        seen.slot      = in_if.slot;
        seen.addr      = in_if.addr;
        seen.mask      = in_if.mask;
        seen.gateway   = in_if.gateway;
        seen.port      = in_if.port;
        seen.ethertype = in_if.ethertype;
        seen.proto     = in_if.proto;
        seen.ttl       = in_if.ttl;
        seen.icmp_kind = in_if.icmp_kind;
        seen.arp_op    = in_if.arp_op;
        board.note_item(seen);
        moved = 1'b1;
      end
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.action        = out_if.action;
        got.icmp_out_type = out_if.icmp_out_type;
        got.icmp_out_code = out_if.icmp_out_code;
        got.out_port      = out_if.out_port;
        got.next_hop      = out_if.next_hop;
        got.ttl_expired   = out_if.ttl_expired;
        board.check_decision(got);
        moved = 1'b1;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // result side back-pressure, switching between patterns
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(24, 160);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= (stall_tick % 3 == 0);
      default: out_if.ready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic item_t noise_item();
    item_t it;
    it.cmd       = CMD_W'($urandom);
    it.slot      = SLOT_W'($urandom);
    it.addr      = $urandom;
    it.mask      = $urandom;
    it.gateway   = $urandom;
    it.port      = PORT_W'($urandom);
    it.ethertype = ETYPE_W'($urandom);
    it.proto     = BYTE_W'($urandom);
    it.ttl       = BYTE_W'($urandom);
    it.icmp_kind = BYTE_W'($urandom);
    it.arp_op    = OP_W'($urandom);
    return it;
  endfunction

  function automatic item_t route_item(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] prefix,
                                       logic [ADDR_W-1:0] mask, logic [ADDR_W-1:0] gw,
                                       logic [PORT_W-1:0] prt);
    item_t it;
    it         = noise_item();
    it.cmd     = CMD_ROUTE;
    it.slot    = slot;
    it.addr    = prefix;
    it.mask    = mask;
    it.gateway = gw;
    it.port    = prt;
    return it;
  endfunction

  function automatic item_t iface_item(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] addr);
    item_t it;
    it      = noise_item();
    it.cmd  = CMD_IFACE;
    it.slot = slot;
    it.addr = addr;
    return it;
  endfunction

  function automatic item_t pkt(logic [ETYPE_W-1:0] et, logic [PORT_W-1:0] prt,
                                logic [ADDR_W-1:0] dst, logic [BYTE_W-1:0] proto,
                                logic [BYTE_W-1:0] ttl, logic [BYTE_W-1:0] kind,
                                logic [OP_W-1:0] op);
    item_t it;
    it           = noise_item();
    it.cmd       = CMD_CLASSIFY;
    it.ethertype = et;
    it.port      = prt;
    it.addr      = dst;
    it.proto     = proto;
    it.ttl       = ttl;
    it.icmp_kind = kind;
    it.arp_op    = op;
    return it;
  endfunction

  // mostly contiguous prefixes over a few shared networks so entries overlap
  function automatic item_t rand_route(logic [SLOT_W-1:0] slot);
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] base;
    int                len;
    int                roll;
    len  = $urandom_range(0, 32);
    mask = ~(32'hFFFFFFFF >> len);
    if ($urandom_range(0, 7) == 0) mask = $urandom;
    roll = $urandom_range(0, 3);
    if (roll == 0) begin
      base = $urandom;
    end else if (roll == 1) begin
      base = board.ifc_addr[$urandom_range(0, 3)];
    end else begin
      base = 32'h0A000000 | ($urandom & 32'h0003FFFF);
    end
    if ($urandom_range(0, 9) == 0) begin
      base = $urandom;
    end else begin
      base = base & mask;
    end
    return route_item(slot, base, mask, ($urandom_range(0, 2) == 0) ? '0 : $urandom,
                      PORT_W'($urandom));
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 10);
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.cmd       <= it.cmd;
    in_if.slot      <= it.slot;
    in_if.addr      <= it.addr;
    in_if.mask      <= it.mask;
    in_if.gateway   <= it.gateway;
    in_if.port      <= it.port;
    in_if.ethertype <= it.ethertype;
    in_if.proto     <= it.proto;
    in_if.ttl       <= it.ttl;
    in_if.icmp_kind <= it.icmp_kind;
    in_if.arp_op    <= it.arp_op;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (board.pending_decisions.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    item_t             it;
    int                roll;
    int                p;
    int                k;
    int                settings;
    logic [ADDR_W-1:0] dst;
    logic [ETYPE_W-1:0] et;
    logic [BYTE_W-1:0] pr;
    logic [BYTE_W-1:0] ttl;
    logic [BYTE_W-1:0] kind;
    logic [OP_W-1:0]   op;

    board = new();
    settings = 0;
    rst_ni = 1'b0;
    in_if.valid     = 1'b0;
    in_if.cmd       = '0;
    in_if.slot      = '0;
    in_if.addr      = '0;
    in_if.mask      = '0;
    in_if.gateway   = '0;
    in_if.port      = '0;
    in_if.ethertype = '0;
    in_if.proto     = '0;
    in_if.ttl       = '0;
    in_if.icmp_kind = '0;
    in_if.arp_op    = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // tables from reset counts: every lookup misses
    send_item(iface_item(4'd0, IF0));
    send_item(iface_item(4'd1, IF1));
    send_item(iface_item(4'd2, IF2));
    send_item(iface_item(4'd3, IF3));
    send_item(iface_item(4'd15, 32'h00000000));
    send_item(route_item(4'd0, 32'h00000000, 32'h00000000, 32'h0A0000FE, 2'd0));
    send_item(route_item(4'd1, 32'h0A000000, 32'hFF000000, 32'h00000000, 2'd1));
    send_item(route_item(4'd2, 32'h0A010000, 32'hFFFF0000, 32'h0A010002, 2'd2));
    send_item(route_item(4'd3, 32'h0A010000, 32'hFFFF0000, 32'h0A010003, 2'd3));
    send_item(pkt(ET_IPV4, 2'd1, 32'h08080808, PR_TCP, 8'd64, 8'd0, 16'd0));
    send_item(pkt(ET_IPV4, 2'd0, IF2, PR_UDP, 8'd64, 8'd0, 16'd0));
    drain();
    write_reg(CFG_ROUTE_COUNT, 8'd4);
    write_reg(CFG_IFACE_COUNT, 8'd4);
    settings++;

    // local delivery, other interface, route selection, arp and oddities
    send_item(pkt(ET_IPV4, 2'd0, IF0, PR_TCP, 8'd64, 8'd0, 16'd0));
    send_item(pkt(ET_IPV6, 2'd1, IF1, PR_UDP, TTL_ONE, 8'd0, 16'd0));
    send_item(pkt(ET_IPV4, 2'd2, IF2, PR_ICMP, TTL_ONE, IC_ECHO_REQ, 16'd0));
    send_item(pkt(ET_IPV4, 2'd2, IF2, PR_ICMP, 8'hFF, IC_ECHO_REQ, 16'd0));
    send_item(pkt(ET_IPV4, 2'd0, IF0, PR_ICMP, 8'd64, IC_ECHO_REPLY, 16'd0));
    send_item(pkt(ET_IPV6, 2'd3, IF3, 8'hFF, 8'd0, 8'hFF, 16'hFFFF));
    send_item(pkt(ET_IPV4, 2'd0, IF2, PR_TCP, 8'd64, 8'd0, 16'd0));
    send_item(pkt(ET_IPV4, 2'd0, 32'h0A010203, PR_TCP, TTL_ONE, 8'd0, 16'd0));
    send_item(pkt(ET_IPV6, 2'd1, 32'h0AC80005, PR_UDP, 8'd64, 8'd0, 16'd0));
    send_item(pkt(ET_IPV4, 2'd3, 32'h08080808, PR_ICMP, 8'd2, IC_ECHO_REQ, 16'd0));
    send_item(pkt(ET_ARP, 2'd1, IF1, 8'd0, 8'd0, 8'd0, ARP_REPLY_CODE));
    send_item(pkt(ET_ARP, 2'd3, IF3, 8'd0, 8'd0, 8'd0, ARP_REQ_CODE));
    send_item(pkt(ET_ARP, 2'd0, IF0, 8'd0, 8'd0, 8'd0, 16'hFFFF));
    send_item(pkt(ET_ARP, 2'd0, IF2, 8'd0, 8'd0, 8'd0, ARP_REQ_CODE));
    send_item(pkt(16'hFFFF, 2'd0, IF0, PR_TCP, 8'd64, 8'd0, 16'd0));
    it = noise_item();
    it.cmd = CMD_UNUSED;
    send_item(it);

    // give every route slot real content before larger counts open them up
    for (int s = 0; s < ROUTE_ENTRIES_DEF; s++) send_item(rand_route(SLOT_W'(s)));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(CFG_ROUTE_COUNT, ROUTE_CFG[ph]);
      write_reg(CFG_IFACE_COUNT, IFACE_CFG[ph]);
      settings++;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          send_item(rand_route(SLOT_W'($urandom)));
        end else if (roll < 13) begin
          if ($urandom_range(0, 2) == 0) begin
            dst = board.ifc_addr[$urandom_range(0, 3)];
          end else if ($urandom_range(0, 1) == 0) begin
            dst = $urandom;
          end else begin
            dst = 32'h0A000000 | ($urandom & 32'h0003FFFF);
          end
          send_item(iface_item(($urandom_range(0, 4) == 0) ? SLOT_W'($urandom) :
                               SLOT_W'($urandom_range(0, 3)), dst));
        end else if (roll < 16) begin
          it = noise_item();
          it.cmd = CMD_UNUSED;
          send_item(it);
        end else begin
          p = $urandom_range(0, 3);
          k = $urandom_range(0, ROUTE_ENTRIES_DEF - 1);
          roll = $urandom_range(0, 99);
          if (roll < 30) begin
            dst = board.ifc_addr[p];
          end else if (roll < 40) begin
            dst = board.ifc_addr[$urandom_range(0, 3)];
          end else if (roll < 80) begin
            dst = board.rt_prefix[k] | ($urandom & ~board.rt_mask[k]);
          end else begin
            dst = $urandom;
          end
          roll = $urandom_range(0, 99);
          et = (roll < 45) ? ET_IPV4 : (roll < 65) ? ET_IPV6 :
               (roll < 90) ? ET_ARP : ETYPE_W'($urandom);
          roll = $urandom_range(0, 99);
          pr = (roll < 35) ? PR_ICMP : (roll < 55) ? PR_TCP :
               (roll < 75) ? PR_UDP : BYTE_W'($urandom);
          ttl  = ($urandom_range(0, 9) < 3) ? TTL_ONE : BYTE_W'($urandom);
          kind = ($urandom_range(0, 1) == 0) ? IC_ECHO_REQ : BYTE_W'($urandom);
          roll = $urandom_range(0, 9);
          op = (roll < 4) ? ARP_REQ_CODE : (roll < 8) ? ARP_REPLY_CODE : OP_W'($urandom);
          send_item(pkt(et, PORT_W'(p), dst, pr, ttl, kind, op));
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.pending_decisions.size() != 0) begin
      $error("%0d decisions never came out", board.pending_decisions.size());
      board.mismatches++;
    end
    $display("%0d items sent over %0d count settings, %0d decisions checked",
             board.noted, settings, board.checked);
    $display("forward %0d, icmp %0d, arp learn %0d, arp answer %0d, drop %0d, writes %0d",
             board.per_action[ACT_FWD], board.per_action[ACT_ICMP],
             board.per_action[ACT_LEARN], board.per_action[ACT_ANSWER],
             board.per_action[ACT_DROP], board.per_action[ACT_WDONE]);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ipfd_pkg.sv
src/ipfd_ifs.sv
src/ipfd_tables.sv
src/ipfd_lpm_tree.sv
src/ipfd_decide.sv
src/ip_router_forwarding_decision.sv
tb/sv/tb_ip_router_forwarding_decision.sv
